@@ hw/rtl/dbd_pkg.sv @@
package dbd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DOY_W   = 9;
  localparam int DNUM_W  = 23;
  localparam int COUNT_W = 22;
  localparam int QUO_W   = 8;

  // Reciprocal of 100 scaled by 2^19; exact floor for every 14-bit operand.
  localparam int          RECIP_SHIFT = 19;
  localparam int          PROD_W      = YEAR_W + RECIP_SHIFT - 6;
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam logic [8:0]  DAYS_YEAR   = 9'd365;
  localparam logic [6:0]  CENTURY     = 7'd100;
  localparam logic [3:0]  MARCH       = 4'd3;
  localparam logic [3:0]  DECEMBER    = 4'd12;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } stage_ld_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [DOY_W-1:0]  doy;
    logic [DNUM_W-1:0] day_num;
  } lane_res_t;

  // Days in the months before the given one of a common year.
  function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    unique case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/dbd_if.sv @@
interface dbd_in_if;
  logic                           valid;
  logic                           ready;
  logic [dbd_pkg::YEAR_W-1:0]     first_year;
  logic [dbd_pkg::MONTH_W-1:0]    first_month;
  logic [dbd_pkg::DAY_W-1:0]      first_day;
  logic [dbd_pkg::YEAR_W-1:0]     second_year;
  logic [dbd_pkg::MONTH_W-1:0]    second_month;
  logic [dbd_pkg::DAY_W-1:0]      second_day;

  modport source (output valid, first_year, first_month, first_day,
                  second_year, second_month, second_day, input ready);
  modport sink (input valid, first_year, first_month, first_day,
                second_year, second_month, second_day, output ready);
endinterface

interface dbd_out_if;
  logic                          valid;
  logic                          ready;
  logic [dbd_pkg::COUNT_W-1:0]   day_count;
  logic                          ordered;

  modport source (output valid, day_count, ordered, input ready);
  modport sink (input valid, day_count, ordered, output ready);
endinterface

interface dbd_cfg_if;
  logic valid;
  logic ready;
  logic count_end_day;

  modport source (output valid, count_end_day, input ready);
  modport sink (input valid, count_end_day, output ready);
endinterface

@@ hw/rtl/dbd_lane.sv @@
// Turns one date into its day number over three register stages.
module dbd_lane #(
  parameter int MAX_YEAR = 9999
) (
  input  logic                          clk,
  input  dbd_pkg::stage_ld_t            ld,
  input  logic [dbd_pkg::YEAR_W-1:0]    year,
  input  logic [dbd_pkg::MONTH_W-1:0]   month,
  input  logic [dbd_pkg::DAY_W-1:0]     day,
  output dbd_pkg::lane_res_t            res
);

  // Stage 1: clamped year and month.
  logic [dbd_pkg::YEAR_W-1:0]  y1;
  logic [dbd_pkg::MONTH_W-1:0] m1;
  logic [dbd_pkg::DAY_W-1:0]   d1;
  logic [dbd_pkg::YEAR_W-1:0]  y1_next;
  logic [dbd_pkg::MONTH_W-1:0] m1_next;

  always_comb begin
    if (17'(year) > 17'(MAX_YEAR)) begin
      y1_next = dbd_pkg::YEAR_W'(MAX_YEAR);
    end else begin
      y1_next = year;
    end
    m1_next = (month > dbd_pkg::DECEMBER) ? dbd_pkg::DECEMBER : month;
  end

  always_ff @(posedge clk) begin
    if (ld.ld1) begin
      y1 <= y1_next;
      m1 <= m1_next;
      d1 <= day;
    end
  end

  // Stage 2: constant multiplications and the month table.
  logic [dbd_pkg::YEAR_W-1:0]  y2;
  logic [dbd_pkg::QUO_W-1:0]   qy;
  logic [dbd_pkg::QUO_W-1:0]   qp;
  logic [dbd_pkg::DNUM_W-1:0]  y365;
  logic [dbd_pkg::DOY_W-1:0]   cum;
  logic                        past_feb;
  logic [dbd_pkg::DAY_W-1:0]   d2;
  logic [dbd_pkg::YEAR_W-1:0]  p1;
  logic [dbd_pkg::PROD_W-1:0]  prod_y;
  logic [dbd_pkg::PROD_W-1:0]  prod_p;
  logic [dbd_pkg::DNUM_W-1:0]  y365_next;

  always_comb begin
    p1        = y1 - dbd_pkg::YEAR_W'(1);
    prod_y    = dbd_pkg::PROD_W'(y1) * dbd_pkg::PROD_W'(dbd_pkg::RECIP_100);
    prod_p    = dbd_pkg::PROD_W'(p1) * dbd_pkg::PROD_W'(dbd_pkg::RECIP_100);
    y365_next = dbd_pkg::DNUM_W'(y1) * dbd_pkg::DNUM_W'(dbd_pkg::DAYS_YEAR);
  end

  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      y2       <= y1;
      qy       <= prod_y[dbd_pkg::RECIP_SHIFT +: dbd_pkg::QUO_W];
      qp       <= prod_p[dbd_pkg::RECIP_SHIFT +: dbd_pkg::QUO_W];
      y365     <= y365_next;
      cum      <= dbd_pkg::cum_days(m1);
      past_feb <= (m1 >= dbd_pkg::MARCH);
      d2       <= d1;
    end
  end

  // Stage 3: leap rule, day of year and day number.
  logic [dbd_pkg::YEAR_W-1:0] rem;
  logic [dbd_pkg::YEAR_W-1:0] p2;
  logic                       leap;
  logic [dbd_pkg::DOY_W-1:0]  doy;
  logic [dbd_pkg::DNUM_W-1:0] dby;

  always_comb begin
    rem  = y2 - dbd_pkg::YEAR_W'(dbd_pkg::YEAR_W'(qy) * dbd_pkg::YEAR_W'(dbd_pkg::CENTURY));
    leap = ((y2[1:0] == 2'b00) && (rem != '0)) || ((rem == '0) && (qy[1:0] == 2'b00));
    doy  = cum + dbd_pkg::DOY_W'(leap && past_feb) + dbd_pkg::DOY_W'(d2);
    p2   = y2 - dbd_pkg::YEAR_W'(1);
    if (y2 == '0) begin
      dby = '0;
    end else begin
      dby = y365 + dbd_pkg::DNUM_W'(p2[dbd_pkg::YEAR_W-1:2]) - dbd_pkg::DNUM_W'(qp)
            + dbd_pkg::DNUM_W'(qp[dbd_pkg::QUO_W-1:2]) + dbd_pkg::DNUM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld3) begin
      res.year    <= y2;
      res.doy     <= doy;
      res.day_num <= dby + dbd_pkg::DNUM_W'(doy);
    end
  end

endmodule

@@ hw/rtl/dbd_merge.sv @@
// Orders the two dates and forms the difference of their day numbers.
module dbd_merge (
  input  logic                           clk,
  input  logic                           ld,
  input  logic                           count_end_day,
  input  dbd_pkg::lane_res_t             start_date,
  input  dbd_pkg::lane_res_t             end_date,
  output logic [dbd_pkg::COUNT_W-1:0]    day_count,
  output logic                           ordered
);

  logic                       lower;
  logic [dbd_pkg::DNUM_W-1:0] diff;

  always_comb begin
    if (start_date.year != end_date.year) begin
      lower = start_date.year < end_date.year;
    end else begin
      lower = start_date.doy < end_date.doy;
    end
    diff = end_date.day_num - start_date.day_num + dbd_pkg::DNUM_W'(count_end_day);
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      ordered   <= lower;
      day_count <= lower ? diff[dbd_pkg::COUNT_W-1:0] : '0;
    end
  end

endmodule

@@ hw/rtl/days_between_dates.sv @@
// Days between two Gregorian dates.
// The dates channel carries a start and an end date (year, month, day); each
// transfer yields exactly one transfer on the result channel with day_count,
// the days from start to end, and ordered, set when the start date is
// strictly earlier. When ordered is clear, day_count is zero.
// The cfg channel writes count_end_day, which adds one so that the end day
// is counted; it is always ready and should be written only while idle.
// A dates transfer passes through three stages in each of two date lanes
// and one merge/output stage. Throughput is one date pair per cycle while
// the receiver keeps result.ready high, set by the fully pipelined lanes.
// When the receiver stalls, the result stays in the output register and the
// stages behind it keep filling; dates.ready drops only once every stage
// holds an item. Reset (rst, synchronous) empties the pipeline and clears
// count_end_day. Years above MAX_YEAR are clamped to MAX_YEAR.
module days_between_dates #(
  parameter int MAX_YEAR = 9999
) (
  input  logic       clk,
  input  logic       rst,
  dbd_in_if.sink     dates,
  dbd_cfg_if.sink    cfg,
  dbd_out_if.source  result
);

  // Configuration register.
  logic count_end_day;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_end_day <= 1'b0;
    end else if (cfg.valid) begin
      count_end_day <= cfg.count_end_day;
    end
  end

  // Valid bits of the pipeline. Each stage takes a new item when it is
  // empty or when its own item moves on, so bubbles close up under a stall.
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  dbd_pkg::stage_ld_t ld;
  logic ld4;

  always_comb begin
    rdy4   = !v4 || result.ready;
    rdy3   = !v3 || rdy4;
    rdy2   = !v2 || rdy3;
    rdy1   = !v1 || rdy2;
    ld.ld1 = dates.valid && rdy1;
    ld.ld2 = v1 && rdy2;
    ld.ld3 = v2 && rdy3;
    ld4    = v3 && rdy4;
  end

  assign dates.ready  = rdy1;
  assign result.valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= dates.valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  // One lane per date; both advance in lockstep.
  dbd_pkg::lane_res_t start_res;
  dbd_pkg::lane_res_t end_res;

  dbd_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_start (
    .clk   (clk),
    .ld    (ld),
    .year  (dates.first_year),
    .month (dates.first_month),
    .day   (dates.first_day),
    .res   (start_res)
  );

  dbd_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_end (
    .clk   (clk),
    .ld    (ld),
    .year  (dates.second_year),
    .month (dates.second_month),
    .day   (dates.second_day),
    .res   (end_res)
  );

  // Merge stage: compare the dates and register the result.
  dbd_merge u_merge (
    .clk           (clk),
    .ld            (ld4),
    .count_end_day (count_end_day),
    .start_date    (start_res),
    .end_date      (end_res),
    .day_count     (result.day_count),
    .ordered       (result.ordered)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// Self-checking bench for days_between_dates.
//
// Date pairs are queued by the stimulus process and presented on the dates
// channel by a clocked driver. Every accepted transfer is run through a
// behavioral day-count predictor, and the prediction is appended to a queue
// of expected spans. A clocked monitor pops that queue on every result
// transfer and compares day_count and ordered field by field.
//
// The run is split into phases. Between phases the bench waits until every
// result has come back, lets the pipeline settle, and then rewrites
// count_end_day through the cfg channel. One phase holds the result channel
// off for a long stretch so the pipeline fills and back-pressures the input;
// another runs with no idle cycles on either side.
module tb_top;

  localparam int YEAR_CAP     = 9999;
  localparam int PIPE_LATENCY = 4;
  localparam int HOLD_CYCLES  = 120;
  localparam int IDLE_PERCENT = 37;

  // One date pair as it travels on the dates channel.
  typedef struct packed {
    logic [dbd_pkg::YEAR_W-1:0]  first_year;
    logic [dbd_pkg::MONTH_W-1:0] first_month;
    logic [dbd_pkg::DAY_W-1:0]   first_day;
    logic [dbd_pkg::YEAR_W-1:0]  second_year;
    logic [dbd_pkg::MONTH_W-1:0] second_month;
    logic [dbd_pkg::DAY_W-1:0]   second_day;
  } date_pair_t;

  // The span the block is expected to report for one date pair.
  typedef struct packed {
    logic [dbd_pkg::COUNT_W-1:0] day_count;
    logic                        ordered;
  } span_t;

  logic clk;
  logic rst;

  dbd_in_if  dates ();
  dbd_cfg_if cfg ();
  dbd_out_if result ();

  days_between_dates #(
    .MAX_YEAR(YEAR_CAP)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .dates(dates),
    .cfg(cfg),
    .result(result)
  );

  // Stimulus and scoreboard state. The predictor keeps its own copy of the
  // count_end_day register, updated whenever a cfg transfer completes.
  date_pair_t pending_dates[$];
  span_t      expected_spans[$];
  date_pair_t shown_pair;
  bit         end_day_cfg;
  int         queued_total;
  int         results_seen;
  int         mismatches;
  logic       no_idle;
  logic       stall_req;
  logic       stall_done;
  int         hold_count;

  // ---------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------

  // Gregorian rule: every fourth year, except centuries not divisible by
  // 400. Year 0 therefore counts as a leap year.
  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    int unsigned common_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m == 2 && leap_year(y)) begin
      return 29;
    end
    return common_len[m - 1];
  endfunction

  // Years beyond the supported range are pinned to the last supported year.
  function automatic int unsigned capped_year(logic [dbd_pkg::YEAR_W-1:0] y);
    return (y > YEAR_CAP) ? YEAR_CAP : int'(y);
  endfunction

  // Months before the given one plus the day of month. Month zero adds no
  // whole months, and any month past December is treated as December. The
  // day is taken as given, even when it is zero or past the month's end.
  function automatic int unsigned year_day(int unsigned y,
                                           logic [dbd_pkg::MONTH_W-1:0] m,
                                           logic [dbd_pkg::DAY_W-1:0] d);
    int unsigned total;
    int unsigned last;
    total = 0;
    last  = (m > 12) ? 12 : int'(m);
    for (int unsigned i = 1; i < last; i++) begin
      total += month_length(y, i);
    end
    return total + d;
  endfunction

  // Days in all years from year 0 up to but not including y.
  function automatic int unsigned days_to_year(int unsigned y);
    int unsigned p;
    if (y == 0) begin
      return 0;
    end
    p = y - 1;
    return y * 365 + p / 4 - p / 100 + p / 400 + 1;
  endfunction

  // Expected result for one pair. Years are compared first; only equal
  // years fall back to comparing day of year. Equal or reversed dates give
  // a zero span with ordered clear.
  function automatic span_t predict_span(date_pair_t p, bit add_end_day);
    int unsigned y1;
    int unsigned y2;
    int unsigned d1;
    int unsigned d2;
    int unsigned diff;
    bit          earlier;
    span_t       s;
    y1      = capped_year(p.first_year);
    y2      = capped_year(p.second_year);
    d1      = year_day(y1, p.first_month, p.first_day);
    d2      = year_day(y2, p.second_month, p.second_day);
    earlier = (y1 != y2) ? (y1 < y2) : (d1 < d2);
    diff    = 0;
    if (earlier) begin
      diff = (days_to_year(y2) + d2) - (days_to_year(y1) + d1) + add_end_day;
    end
    s.day_count = dbd_pkg::COUNT_W'(diff);
    s.ordered   = earlier;
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------

  function automatic date_pair_t make_pair(int y1, int m1, int d1, int y2, int m2, int d2);
    date_pair_t p;
    p.first_year   = dbd_pkg::YEAR_W'(y1);
    p.first_month  = dbd_pkg::MONTH_W'(m1);
    p.first_day    = dbd_pkg::DAY_W'(d1);
    p.second_year  = dbd_pkg::YEAR_W'(y2);
    p.second_month = dbd_pkg::MONTH_W'(m2);
    p.second_day   = dbd_pkg::DAY_W'(d2);
    return p;
  endfunction

  // Mostly ordinary years, with a share of century boundaries (where the
  // leap rule gets interesting) and of years past the supported range.
  function automatic logic [dbd_pkg::YEAR_W-1:0] random_year();
    int unsigned kind;
    kind = $urandom_range(9);
    if (kind < 7) begin
      return dbd_pkg::YEAR_W'($urandom_range(0, YEAR_CAP));
    end
    if (kind < 9) begin
      return dbd_pkg::YEAR_W'($urandom_range(1, 99) * 100 + $urandom_range(0, 2) - 1);
    end
    return dbd_pkg::YEAR_W'($urandom_range(YEAR_CAP + 1, (1 << dbd_pkg::YEAR_W) - 1));
  endfunction

  // About a quarter of the pairs are raw bit patterns, which covers invalid
  // months and days and every bit of every field. The rest are real dates,
  // with the second date often identical, in the same year, or one year off
  // so that the same-year and year-boundary comparisons are well exercised.
  function automatic date_pair_t random_pair();
    date_pair_t  p;
    int unsigned shape;
    shape = $urandom_range(99);
    if (shape < 25) begin
      p.first_year   = dbd_pkg::YEAR_W'($urandom);
      p.first_month  = dbd_pkg::MONTH_W'($urandom);
      p.first_day    = dbd_pkg::DAY_W'($urandom);
      p.second_year  = dbd_pkg::YEAR_W'($urandom);
      p.second_month = dbd_pkg::MONTH_W'($urandom);
      p.second_day   = dbd_pkg::DAY_W'($urandom);
      return p;
    end
    p.first_year  = random_year();
    p.first_month = dbd_pkg::MONTH_W'($urandom_range(1, 12));
    p.first_day   = dbd_pkg::DAY_W'($urandom_range(1,
                      month_length(p.first_year, p.first_month)));
    if (shape < 33) begin
      p.second_year  = p.first_year;
      p.second_month = p.first_month;
      p.second_day   = p.first_day;
      return p;
    end
    if (shape < 56) begin
      p.second_year = p.first_year;
    end else if (shape < 76) begin
      p.second_year = dbd_pkg::YEAR_W'(int'(p.first_year) + ($urandom_range(1) ? 1 : -1));
    end else begin
      p.second_year = random_year();
    end
    p.second_month = dbd_pkg::MONTH_W'($urandom_range(1, 12));
    p.second_day   = dbd_pkg::DAY_W'($urandom_range(1,
                       month_length(p.second_year, p.second_month)));
    return p;
  endfunction

  task automatic push_pair(date_pair_t p);
    pending_dates.push_back(p);
    queued_total++;
  endtask

  // Blocks until every queued pair has produced its result, then lets the
  // pipeline run out before anything else touches the block.
  task automatic wait_idle();
    while (results_seen < queued_total) begin
      @(posedge clk);
    end
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  // Single write on the cfg channel; only called while the block is idle.
  task automatic set_end_day(bit value);
    @(posedge clk);
    cfg.valid         <= 1'b1;
    cfg.count_end_day <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid   <= 1'b0;
    end_day_cfg  = value;
  endtask

  // ---------------------------------------------------------------------
  // Clock, run length guard
  // ---------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Dates driver
  // ---------------------------------------------------------------------

  // When the current pair transfers, its prediction is recorded. A new pair
  // is offered whenever the channel is free, unless this cycle idles. The
  // valid line is only written once per edge so a back-to-back stream keeps
  // it high without a glitch.
  always @(posedge clk) begin : dates_driver
    date_pair_t offered;
    if (rst) begin
      dates.valid <= 1'b0;
    end else begin
      if (dates.valid && dates.ready) begin
        expected_spans.push_back(predict_span(shown_pair, end_day_cfg));
      end
      if (!dates.valid || dates.ready) begin
        if (pending_dates.size() != 0 &&
            (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
          offered             = pending_dates.pop_front();
          shown_pair         <= offered;
          dates.first_year   <= offered.first_year;
          dates.first_month  <= offered.first_month;
          dates.first_day    <= offered.first_day;
          dates.second_year  <= offered.second_year;
          dates.second_month <= offered.second_month;
          dates.second_day   <= offered.second_day;
          dates.valid        <= 1'b1;
        end else begin
          dates.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result receiver
  // ---------------------------------------------------------------------

  // Random back-pressure on the result channel. Once a long hold is
  // requested, ready stays low until stall_done is set while the driver keeps
  // offering pairs, which fills every pipeline stage and stalls the input.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      hold_count   <= 0;
      stall_done   <= 1'b0;
    end else if (stall_req && !stall_done) begin
      result.ready <= 1'b0;
      hold_count   <= hold_count + 1;
      if (hold_count == HOLD_CYCLES - 1) begin
        stall_done <= 1'b1;
      end
    end else begin
      result.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Every result transfer is matched against the oldest prediction. A
  // result with nothing waiting counts as a failure too.
  always @(posedge clk) begin : result_monitor
    span_t want;
    if (!rst && result.valid && result.ready) begin
      results_seen++;
      if (expected_spans.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual day_count=%0d ordered=%0b",
                 $time, result.day_count, result.ordered);
        mismatches++;
      end else begin
        want = expected_spans.pop_front();
        if (result.day_count !== want.day_count) begin
          $display("%0t: day_count mismatch, expected %0d, actual %0d",
                   $time, want.day_count, result.day_count);
          mismatches++;
        end
        if (result.ordered !== want.ordered) begin
          $display("%0t: ordered mismatch, expected %0b, actual %0b",
                   $time, want.ordered, result.ordered);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------

  initial begin
    // Every input is known from time zero.
    rst                = 1'b1;
    dates.valid        = 1'b0;
    dates.first_year   = '0;
    dates.first_month  = '0;
    dates.first_day    = '0;
    dates.second_year  = '0;
    dates.second_month = '0;
    dates.second_day   = '0;
    cfg.valid          = 1'b0;
    cfg.count_end_day  = 1'b0;
    result.ready       = 1'b0;
    shown_pair         = '0;
    end_day_cfg        = 1'b0;
    queued_total       = 0;
    results_seen       = 0;
    mismatches         = 0;
    no_idle            = 1'b0;
    stall_req          = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed pairs with the end day not counted.
    set_end_day(1'b0);
    // Widest span, and the same pair reversed.
    push_pair(make_pair(0, 1, 1, 9999, 12, 31));
    push_pair(make_pair(9999, 12, 31, 0, 1, 1));
    // Equal dates are not ordered.
    push_pair(make_pair(2024, 5, 17, 2024, 5, 17));
    // Leap rule: divisible by 400, century, ordinary, and year zero.
    push_pair(make_pair(2000, 2, 28, 2000, 3, 1));
    push_pair(make_pair(1900, 2, 28, 1900, 3, 1));
    push_pair(make_pair(2023, 12, 31, 2024, 1, 1));
    push_pair(make_pair(0, 2, 28, 0, 3, 1));
    push_pair(make_pair(1600, 2, 29, 2100, 2, 28));
    push_pair(make_pair(400, 2, 29, 401, 2, 28));
    // Years beyond the cap collapse onto the last supported year.
    push_pair(make_pair(16383, 1, 1, 9999, 1, 2));
    push_pair(make_pair(10000, 6, 1, 12000, 6, 1));
    // Month zero behaves as January; months past twelve as December.
    push_pair(make_pair(2020, 0, 10, 2020, 1, 11));
    push_pair(make_pair(2020, 15, 1, 2020, 12, 2));
    push_pair(make_pair(2021, 13, 31, 2022, 1, 1));
    // Day zero and a day past the month's end are taken literally.
    push_pair(make_pair(2021, 3, 0, 2021, 3, 1));
    push_pair(make_pair(2021, 2, 31, 2021, 3, 1));
    push_pair(make_pair(2021, 12, 31, 2022, 1, 0));
    // Whole-year steps and the top of the range.
    push_pair(make_pair(1999, 1, 1, 2000, 1, 1));
    push_pair(make_pair(9998, 7, 4, 9999, 7, 4));
    // Same year reversed, and reversed by year alone.
    push_pair(make_pair(2024, 3, 1, 2024, 2, 29));
    push_pair(make_pair(1, 1, 1, 0, 12, 31));
    // All-zero and all-one field patterns.
    push_pair(make_pair(0, 0, 0, 0, 0, 1));
    push_pair(make_pair(16383, 15, 31, 16383, 15, 31));
    push_pair(make_pair(0, 0, 0, 16383, 15, 31));
    wait_idle();

    // End day counted, with a long receiver hold early in the phase.
    set_end_day(1'b1);
    for (int i = 0; i < 500; i++) begin
      push_pair(random_pair());
    end
    stall_req <= 1'b1;
    wait_idle();

    // Full-rate stretch: neither side idles.
    set_end_day(1'b0);
    no_idle <= 1'b1;
    for (int i = 0; i < 400; i++) begin
      push_pair(random_pair());
    end
    wait_idle();
    no_idle <= 1'b0;

    set_end_day(1'b1);
    for (int i = 0; i < 450; i++) begin
      push_pair(random_pair());
    end
    wait_idle();

    set_end_day(1'b0);
    for (int i = 0; i < 400; i++) begin
      push_pair(random_pair());
    end
    wait_idle();

    if (mismatches == 0 && expected_spans.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
